// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/wblur_pkg.sv =====
// types and constants of the weighted 3x3 blur
`default_nettype none
package wblur_pkg;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_WEIGHT = 2'd2;

    typedef struct packed {
        logic [10:0]      x;
        logic [11:0]      y;
        logic [2:0][7:0]  centre;
        logic [2:0][10:0] nsum;
        logic             last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage
`default_nettype wire

// ===== sv/wblur_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module wblur_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== sv/wblur_front.sv =====
// front end: position counters, line stores, window and job building
`default_nettype none
module wblur_front
    import wblur_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [23:0] i_px,
    input  wire logic        i_fs,
    input  wire logic [11:0] i_eff_w,
    input  wire logic [12:0] i_eff_h,
    input  wire t_qstat      i_qstat,
    output logic             o_push,
    output t_job             o_job
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RD   = 1'b1;

    logic        r_state;
    logic [10:0] r_col, r_x;
    logic [11:0] r_row, r_y;
    logic [23:0] r_px;
    logic        r_inr;
    logic [23:0] r_win [6];

    logic        accept, inr_a, done, out_cond;
    logic [10:0] ax, n_col;
    logic [11:0] ay, n_row;
    logic [23:0] up_rd, mid_rd, up, mid;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;
    assign ax      = i_fs ? 11'd0 : r_col;
    assign ay      = i_fs ? 12'd0 : r_row;
    assign inr_a   = 32'(ax) < MAX_WIDTH;

    always_comb begin
        n_col = ax + 11'd1;
        n_row = ay;
        if ({2'b0, ax} >= {1'b0, i_eff_w} - 13'd1) begin
            n_col = '0;
            n_row = ({1'b0, ay} >= i_eff_h - 13'd1) ? 12'd0 : ay + 12'd1;
        end
    end

    wblur_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_mid (
        .i_clk(i_clk), .i_we(accept && inr_a), .i_waddr(AW'(ax)), .i_wdata(i_px),
        .i_re(accept), .i_raddr(AW'(ax)), .o_rdata(mid_rd)
    );

    wblur_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_up (
        .i_clk(i_clk), .i_we((r_state == ST_RD) && r_inr), .i_waddr(AW'(r_x)),
        .i_wdata(mid_rd), .i_re(accept), .i_raddr(AW'(ax)), .o_rdata(up_rd)
    );

    assign up  = r_inr ? up_rd : 24'd0;
    assign mid = r_inr ? mid_rd : 24'd0;

    assign out_cond = (r_x >= 11'd2) && (r_y >= 12'd2) && ({1'b0, r_x} < i_eff_w)
                      && ({1'b0, r_y} < i_eff_h);
    assign done     = (r_state == ST_RD) && (!out_cond || !i_qstat.full);
    assign o_push   = (r_state == ST_RD) && out_cond && !i_qstat.full;

    always_comb begin
        o_job.x    = r_x - 11'd1;
        o_job.y    = r_y - 12'd1;
        o_job.last = ({1'b0, r_x} == i_eff_w - 12'd1) && ({1'b0, r_y} == i_eff_h - 13'd1);
        for (int c = 0; c < 3; c++) begin
            o_job.centre[c] = r_win[4][c*8 +: 8];
            o_job.nsum[c]   = 11'(r_win[0][c*8 +: 8]) + 11'(r_win[3][c*8 +: 8])
                            + 11'(up[c*8 +: 8])       + 11'(r_win[1][c*8 +: 8])
                            + 11'(mid[c*8 +: 8])      + 11'(r_win[2][c*8 +: 8])
                            + 11'(r_win[5][c*8 +: 8]) + 11'(r_px[c*8 +: 8]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (accept) begin
                r_state <= ST_RD;
                r_col   <= n_col;
                r_row   <= n_row;
            end
            if (done) begin
                r_state  <= ST_IDLE;
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= up;
                r_win[4] <= mid;
                r_win[5] <= r_px;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x   <= ax;
            r_y   <= ay;
            r_px  <= i_px;
            r_inr <= inr_a;
        end
    end
endmodule
`default_nettype wire

// ===== sv/wblur_fifo.sv =====
// two entry job queue between front and back
`default_nettype none
module wblur_fifo
    import wblur_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output t_qstat    o_stat
);
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_job        = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end
endmodule
`default_nettype wire

// ===== sv/wblur_back.sv =====
// back end: weighted sum, serial division, rounding and saturation
`default_nettype none
module wblur_back
    import wblur_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_job       i_job,
    input  wire t_qstat     i_qstat,
    output logic            o_pop,
    input  wire logic [7:0] i_weight,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [10:0]     o_x,
    output logic [11:0]     o_y,
    output logic [2:0][7:0] o_chan,
    output logic            o_last
);
    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_MUL  = 2'd1;
    localparam logic [1:0] B_DIV  = 2'd2;
    localparam logic [1:0] B_DONE = 2'd3;

    logic [1:0]        r_state;
    t_job              r_job;
    logic [2:0][19:0]  r_num;
    logic [2:0][11:0]  r_rem;
    logic [11:0]       r_den;
    logic [4:0]        r_cnt;
    logic              load;
    logic [11:0]       den;
    logic [2:0][12:0]  trial;

    assign o_pop = (r_state == B_IDLE) && !i_qstat.empty;
    assign load  = (r_state == B_DONE) && (!o_valid || i_ready);
    assign den   = {1'b0, i_weight, 3'b0} + 12'd16;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            trial[c] = {r_rem[c], r_num[c][19]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                B_IDLE: if (o_pop) begin
                    r_state <= B_MUL;
                end
                B_MUL: r_state <= B_DIV;
                B_DIV: if (r_cnt == 5'd0) begin
                    r_state <= B_DONE;
                end
                B_DONE: if (load) begin
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
            if (load) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == B_MUL) begin
            r_den <= den;
            r_cnt <= 5'd19;
            for (int c = 0; c < 3; c++) begin
                r_num[c] <= {8'd0, r_job.centre[c], 4'd0}
                          + ({12'd0, i_weight} * {9'd0, r_job.nsum[c]}) + 20'(den[11:1]);
                r_rem[c] <= '0;
            end
        end
        if (r_state == B_DIV) begin
            r_cnt <= r_cnt - 5'd1;
            for (int c = 0; c < 3; c++) begin
                if (trial[c] >= {1'b0, r_den}) begin
                    r_rem[c] <= 12'(trial[c] - {1'b0, r_den});
                    r_num[c] <= {r_num[c][18:0], 1'b1};
                end else begin
                    r_rem[c] <= trial[c][11:0];
                    r_num[c] <= {r_num[c][18:0], 1'b0};
                end
            end
        end
        if (load) begin
            o_x    <= r_job.x;
            o_y    <= r_job.y;
            o_last <= r_job.last;
            for (int c = 0; c < 3; c++) begin
                o_chan[c] <= (r_num[c] > 20'd255) ? 8'hff : r_num[c][7:0];
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/weighted_3x3_blur.sv =====
// top level of the weighted 3x3 blur
// Weighted 3x3 blur for an RGB pixel stream in raster order. Each interior
// pixel comes out as (16*centre + w*sum_of_8_neighbours + D/2) / D per channel,
// D = 16 + 8*w, w the Q4.4 neighbour weight, saturated to 255; border pixels
// give no result. A pixel occupies the front end for a line store read then
// a window update, which waits while the queue is full and a result is due.
// The back end then runs a 20 step bit-serial divider on all three channels
// in parallel and takes a new pixel only once the last is in the output
// register. A two entry queue and the output register decouple the two halves.
`default_nettype none
`include "assert_macros.svh"
module weighted_3x3_blur
    import wblur_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // in_blue, in_green, in_red
    input  wire logic        s_axis_tuser,   // frame_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // out_blue, out_green, out_red, out_y, out_x
    output logic             m_axis_tlast,   // frame_end
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int WLIM = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;

    logic [11:0]      r_width;
    logic [12:0]      r_height;
    logic [7:0]       r_weight;
    logic [11:0]      eff_w;
    logic [12:0]      eff_h;
    logic             cfg_wr, push, pop;
    t_job             fjob, qjob;
    t_qstat           qstat;
    logic [10:0]      ox;
    logic [11:0]      oy;
    logic [2:0][7:0]  ochan;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 12'd640;
            r_height <= 13'd480;
            r_weight <= 8'd16;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_WIDTH:  r_width  <= pwdata[11:0];
                REG_HEIGHT: r_height <= pwdata[12:0];
                REG_WEIGHT: r_weight <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = {20'd0, r_width};
            REG_HEIGHT: prdata = {19'd0, r_height};
            REG_WEIGHT: prdata = {24'd0, r_weight};
            default:    prdata = '0;
        endcase
    end

    assign eff_w = (r_width < 12'd3) ? 12'd3 :
                   (32'(r_width) > WLIM) ? 12'(WLIM) : r_width;
    assign eff_h = (r_height < 13'd3) ? 13'd3 :
                   (r_height > 13'd4096) ? 13'd4096 : r_height;

    wblur_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_px(s_axis_tdata), .i_fs(s_axis_tuser), .i_eff_w(eff_w), .i_eff_h(eff_h),
        .i_qstat(qstat), .o_push(push), .o_job(fjob)
    );

    wblur_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(fjob),
        .i_pop(pop), .o_job(qjob), .o_stat(qstat)
    );

    wblur_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job(qjob), .i_qstat(qstat), .o_pop(pop),
        .i_weight(r_weight), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_x(ox), .o_y(oy), .o_chan(ochan), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, ochan[2], ochan[1], ochan[0], oy, ox};

    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, push && qstat.full, "push into full queue")
    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, pop && qstat.empty, "pop from empty queue")
    `ASSERT_IMPLY(a_out_hold, i_clk, i_rst_n, $past(m_axis_tvalid && !m_axis_tready), m_axis_tvalid && $stable(m_axis_tdata), "stalled output transfer changed")
endmodule
`default_nettype wire
